// ----- hdl/bswup_pkg.sv -----
// Shared types and codes for the byte stack with unique push.
`timescale 1ns / 1ps

package bswup_pkg;

    localparam int ByteW   = 8;
    localparam int CmdW    = 2;
    localparam int StatusW = 2;
    localparam int CountOutW = 5;

    typedef enum logic [CmdW-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_UNIQUE = 2'd3
    } t_cmd;

    typedef enum logic [StatusW-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_MATCH = 2'd3
    } t_status;

    // Shift control broadcast to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_op;

endpackage

// ----- hdl/bswup_cell.sv -----
// One storage cell of the stack chain: holds an entry, shifts and compares.
`timescale 1ns / 1ps

module bswup_cell #(
    parameter int CellIdx = 0,
    parameter int CountW  = 5
) (
    input  logic                      i_clk,
    input  bswup_pkg::t_cell_op       i_op,
    input  logic [bswup_pkg::ByteW-1:0] i_above,
    input  logic [bswup_pkg::ByteW-1:0] i_below,
    input  logic [bswup_pkg::ByteW-1:0] i_key,
    input  logic [CountW-1:0]         i_count,
    output logic [bswup_pkg::ByteW-1:0] o_data,
    output logic                      o_hit
);

    logic [bswup_pkg::ByteW-1:0] r_data;

    // A push moves every entry one place away from the top, a pop one place towards it.
    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_data <= i_above;
        end else if (i_op.pop) begin
            r_data <= i_below;
        end
    end

    assign o_data = r_data;
    // Only cells below the fill level hold live entries.
    assign o_hit  = (r_data == i_key) && (CountW'(CellIdx) < i_count);

endmodule

// ----- hdl/byte_stack_with_unique_push.sv -----
// Top level of the byte stack with duplicate-checked push.
//
// Usage: each beat on the slave stream carries a command and a byte; each
// command returns exactly one beat on the master stream with the top value
// (peek only), a status code and the entry count after the command.
// Commands are push, pop, peek and unique push; unique push stores the byte
// only when no stored entry equals it.
// Storage is a chain of cells, one per entry, with the top in the first cell.
// Every cell compares its entry with the byte at once and all cells shift
// together, so a command is worked out in its execute state after it is taken.
// The result is loaded into the output register as the command completes.
// The control takes a beat in its idle state, then does the compare and shift
// across the chain in its execute state; no new beat is taken until it completes.
// The next command is taken while a result still waits on the master side;
// if the receiver stalls, that command waits in its execute state until the
// output register frees, and no further beat is taken meanwhile.
// Reset empties the stack (the fill count is cleared) and drops any pending
// result; entry contents are not cleared.
`timescale 1ns / 1ps

module byte_stack_with_unique_push #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // command [1:0], data_byte [9:2], zero [15:10]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // top_value [7:0], status [9:8],
                                          // entry_count [14:10], zero [15]
);

    localparam int CountW = $clog2(STACK_DEPTH + 1);
    localparam int ByteW  = bswup_pkg::ByteW;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                 r_state, n_state;
    bswup_pkg::t_cmd        r_cmd;
    logic [ByteW-1:0]       r_byte;
    logic [CountW-1:0]      r_count, n_count;
    logic                   r_out_valid;
    logic [15:0]            r_out_data;

    logic [ByteW-1:0]       w_data [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] w_hit;
    bswup_pkg::t_cell_op    w_op;
    bswup_pkg::t_status     w_status;
    logic [ByteW-1:0]       w_top;
    logic                   w_in_fire;
    logic                   w_done;
    logic                   w_full;
    logic                   w_empty;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_done          = (r_state == S_EXEC) && (!r_out_valid || i_m_axis_tready);
    assign w_full          = (r_count == CountW'(STACK_DEPTH));
    assign w_empty         = (r_count == '0);

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            logic [ByteW-1:0] w_above;
            logic [ByteW-1:0] w_below;
            if (gi == 0) begin : g_first
                assign w_above = r_byte;
            end else begin : g_mid_above
                assign w_above = w_data[gi-1];
            end
            if (gi == STACK_DEPTH - 1) begin : g_last
                assign w_below = w_data[gi];
            end else begin : g_mid_below
                assign w_below = w_data[gi+1];
            end
            bswup_cell #(
                .CellIdx (gi),
                .CountW  (CountW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op),
                .i_above (w_above),
                .i_below (w_below),
                .i_key   (r_byte),
                .i_count (r_count),
                .o_data  (w_data[gi]),
                .o_hit   (w_hit[gi])
            );
        end
    endgenerate

    always_comb begin
        w_op     = '0;
        w_status = bswup_pkg::ST_OK;
        w_top    = '0;
        n_count  = r_count;
        unique case (r_cmd)
            bswup_pkg::CMD_PUSH: begin
                if (w_full) begin
                    w_status = bswup_pkg::ST_FULL;
                end else begin
                    w_op.push = w_done;
                    n_count   = r_count + 1'b1;
                end
            end
            bswup_pkg::CMD_POP: begin
                if (w_empty) begin
                    w_status = bswup_pkg::ST_EMPTY;
                end else begin
                    w_op.pop = w_done;
                    n_count  = r_count - 1'b1;
                end
            end
            bswup_pkg::CMD_PEEK: begin
                if (w_empty) begin
                    w_status = bswup_pkg::ST_EMPTY;
                end else begin
                    w_top = w_data[0];
                end
            end
            bswup_pkg::CMD_UNIQUE: begin
                if (|w_hit) begin
                    w_status = bswup_pkg::ST_MATCH;
                end else if (w_full) begin
                    w_status = bswup_pkg::ST_FULL;
                end else begin
                    w_op.push = w_done;
                    n_count   = r_count + 1'b1;
                end
            end
            default: begin
                w_status = bswup_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_fire) n_state = S_EXEC;
            S_EXEC: if (w_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_done) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_cmd  <= bswup_pkg::t_cmd'(i_s_axis_tdata[1:0]);
            r_byte <= i_s_axis_tdata[9:2];
        end
        if (w_done) begin
            r_out_data <= {1'b0, bswup_pkg::CountOutW'(n_count), w_status, w_top};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(STACK_DEPTH))
        else $error("fill count beyond stack depth");

    a_push_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op.push |=> r_count == $past(r_count) + 1'b1)
        else $error("push did not raise the fill count");

    a_pop_shrinks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op.pop |=> r_count == $past(r_count) - 1'b1)
        else $error("pop did not lower the fill count");

    a_match_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && w_status == bswup_pkg::ST_MATCH) |-> (w_op == '0 && n_count == r_count))
        else $error("matched unique push changed the stack");

    a_op_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op.push || w_op.pop) |-> (w_done && !(w_op.push && w_op.pop)))
        else $error("shift issued outside a completing command");

endmodule

// ----- dv/tb.sv -----
// Self-checking stream testbench for the byte stack with unique push.
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH        = 16;
    localparam int RANDOM_CMDS  = 450;
    localparam int LIMIT_CYCLES = 100000;
    localparam int IDLE_PCT     = 22;
    localparam int HOLD_CYCLES  = 60;

    // One result beat as it appears on the master tdata, lowest field last.
    typedef struct packed {
        logic               pad;
        logic [4:0]         count;
        bswup_pkg::t_status status;
        logic [7:0]         top;
    } t_stack_result;

    typedef struct packed {
        bswup_pkg::t_cmd cmd;
        logic [7:0]      data;
        logic [4:0]      reps;
        logic            typed;
        t_stack_result   want;
    } t_dir_row;

    typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIX} t_seg_kind;

    // Rows with typed set carry a result that is fixed by the command alone;
    // the rest are checked against the predictor. Repeated rows add one to
    // the byte on each repetition.
    localparam t_dir_row DIR_ROWS [14] = '{
        '{bswup_pkg::CMD_PEEK, 8'h00, 5'd1, 1'b1, '{1'b0, 5'd0, bswup_pkg::ST_EMPTY, 8'h00}},
        '{bswup_pkg::CMD_POP, 8'h5A, 5'd1, 1'b1, '{1'b0, 5'd0, bswup_pkg::ST_EMPTY, 8'h00}},
        '{bswup_pkg::CMD_UNIQUE, 8'h00, 5'd1, 1'b1, '{1'b0, 5'd1, bswup_pkg::ST_OK, 8'h00}},
        '{bswup_pkg::CMD_PUSH, 8'hFF, 5'd1, 1'b1, '{1'b0, 5'd2, bswup_pkg::ST_OK, 8'h00}},
        '{bswup_pkg::CMD_PEEK, 8'h00, 5'd1, 1'b1, '{1'b0, 5'd2, bswup_pkg::ST_OK, 8'hFF}},
        '{bswup_pkg::CMD_UNIQUE, 8'h00, 5'd1, 1'b1, '{1'b0, 5'd2, bswup_pkg::ST_MATCH, 8'h00}},
        '{bswup_pkg::CMD_UNIQUE, 8'hFF, 5'd1, 1'b1, '{1'b0, 5'd2, bswup_pkg::ST_MATCH, 8'h00}},
        '{bswup_pkg::CMD_PUSH, 8'h10, 5'd14, 1'b0, '{1'b0, 5'd0, bswup_pkg::ST_OK, 8'h00}},
        '{bswup_pkg::CMD_PUSH, 8'h01, 5'd1, 1'b1, '{1'b0, 5'd16, bswup_pkg::ST_FULL, 8'h00}},
        '{bswup_pkg::CMD_UNIQUE, 8'h7E, 5'd1, 1'b1, '{1'b0, 5'd16, bswup_pkg::ST_FULL, 8'h00}},
        '{bswup_pkg::CMD_UNIQUE, 8'h15, 5'd1, 1'b1, '{1'b0, 5'd16, bswup_pkg::ST_MATCH, 8'h00}},
        '{bswup_pkg::CMD_PEEK, 8'h00, 5'd1, 1'b1, '{1'b0, 5'd16, bswup_pkg::ST_OK, 8'h1D}},
        '{bswup_pkg::CMD_POP, 8'h00, 5'd1, 1'b1, '{1'b0, 5'd15, bswup_pkg::ST_OK, 8'h00}},
        '{bswup_pkg::CMD_UNIQUE, 8'h1D, 5'd1, 1'b0, '{1'b0, 5'd0, bswup_pkg::ST_OK, 8'h00}}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata;    // command [1:0], data_byte [9:2], zero [15:10]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [15:0] o_m_axis_tdata;    // top_value [7:0], status [9:8],
                                    // entry_count [14:10], zero [15]

    logic [7:0]    model_entries [DEPTH];
    int            model_fill;
    t_stack_result pending_results [$];
    int            n_sent;
    int            n_checked;
    int            n_fail;
    int            cycle_cnt;

    byte_stack_with_unique_push #(
        .STACK_DEPTH(DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Works out the result of one command and moves the stack state on.
    function automatic t_stack_result predict_stack_result(bswup_pkg::t_cmd cmd,
                                                           logic [7:0] data);
        t_stack_result res;
        bit            found;
        res        = '0;
        res.status = bswup_pkg::ST_OK;
        found      = 1'b0;
        case (cmd)
            bswup_pkg::CMD_POP: begin
                if (model_fill == 0)
                    res.status = bswup_pkg::ST_EMPTY;
                else
                    model_fill--;
            end
            bswup_pkg::CMD_PEEK: begin
                if (model_fill == 0)
                    res.status = bswup_pkg::ST_EMPTY;
                else
                    res.top = model_entries[model_fill - 1];
            end
            default: begin
                if (cmd == bswup_pkg::CMD_UNIQUE)
                    for (int i = 0; i < model_fill; i++)
                        if (model_entries[i] == data)
                            found = 1'b1;
                // A match takes precedence over a full stack.
                if (found) begin
                    res.status = bswup_pkg::ST_MATCH;
                end else if (model_fill >= DEPTH) begin
                    res.status = bswup_pkg::ST_FULL;
                end else begin
                    model_entries[model_fill] = data;
                    model_fill++;
                end
            end
        endcase
        res.count = model_fill[4:0];
        return res;
    endfunction

    // Offers one beat, with random idle cycles ahead of it unless calm.
    task automatic send_command(input bswup_pkg::t_cmd cmd, input logic [7:0] data,
                                input bit calm);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'd0, data, cmd};
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_sent++;
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Stimulus: directed table first, then random segments that lean towards
    // filling or draining the stack, or mix all commands evenly.
    initial begin : stimulus
        t_stack_result   exp_res;
        t_seg_kind       seg;
        int              seg_left;
        int              n_rand;
        int              pick;
        bswup_pkg::t_cmd cmd;
        logic [7:0]      data;

        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        model_fill      = 0;
        n_sent          = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[r]) begin
            for (int k = 0; k < DIR_ROWS[r].reps; k++) begin
                data = DIR_ROWS[r].data + k[7:0];
                send_command(DIR_ROWS[r].cmd, data, 1'b0);
                exp_res = predict_stack_result(DIR_ROWS[r].cmd, data);
                if (DIR_ROWS[r].typed)
                    exp_res = DIR_ROWS[r].want;
                pending_results.push_back(exp_res);
            end
        end
        wait_results_drained();

        seg_left = 0;
        seg      = SEG_MIX;
        for (n_rand = 0; n_rand < RANDOM_CMDS; n_rand++) begin
            if (seg_left == 0) begin
                seg      = t_seg_kind'($urandom_range(0, 2));
                seg_left = $urandom_range(4, 24);
            end
            seg_left--;
            pick = $urandom_range(0, 99);
            case (seg)
                SEG_FILL:
                    cmd = pick < 45 ? bswup_pkg::CMD_PUSH :
                          pick < 80 ? bswup_pkg::CMD_UNIQUE :
                          pick < 90 ? bswup_pkg::CMD_PEEK : bswup_pkg::CMD_POP;
                SEG_DRAIN:
                    cmd = pick < 50 ? bswup_pkg::CMD_POP :
                          pick < 75 ? bswup_pkg::CMD_PEEK :
                          pick < 88 ? bswup_pkg::CMD_PUSH : bswup_pkg::CMD_UNIQUE;
                default:
                    cmd = bswup_pkg::t_cmd'($urandom_range(0, 3));
            endcase
            // Bytes already on the stack make matches and duplicates likely.
            pick = $urandom_range(0, 99);
            if (pick < 40 && model_fill > 0)
                data = model_entries[$urandom_range(0, model_fill - 1)];
            else if (pick < 60)
                data = 8'($urandom_range(0, 7));
            else
                data = 8'($urandom_range(0, 255));
            if (n_rand == 330)
                wait_results_drained();
            send_command(cmd, data, n_rand >= 200 && n_rand < 280);
            pending_results.push_back(predict_stack_result(cmd, data));
        end

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            n_fail++;
        end
        if (n_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Result side: random back-pressure, one long hold-off while the sender
    // keeps offering, and a calm stretch.
    initial begin : sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && n_sent >= 150) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (n_checked >= 320 && n_checked < 400) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        n_checked = 0;
        n_fail    = 0;
    end

    always @(posedge i_clk) begin
        t_stack_result got;
        t_stack_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_checked++;
            got = o_m_axis_tdata;
            if (pending_results.size() == 0) begin
                $error("result beat %h with no command outstanding", o_m_axis_tdata);
                n_fail++;
            end else begin
                want = pending_results.pop_front();
                if (got.top !== want.top) begin
                    $error("top_value: expected %0h, got %0h", want.top, got.top);
                    n_fail++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    n_fail++;
                end
                if (got.count !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count, got.count);
                    n_fail++;
                end
                if (got.pad !== want.pad) begin
                    $error("tdata spare bit: expected %0b, got %0b", want.pad, got.pad);
                    n_fail++;
                end
            end
        end
    end

    initial cycle_cnt = 0;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

// ----- sim.f -----
hdl/bswup_pkg.sv
hdl/bswup_cell.sv
hdl/byte_stack_with_unique_push.sv
dv/tb.sv
